>>> rtl/rrbc_pkg.sv
// Shared types and constants for the ROM/RAM bank controller.
package rrbc_pkg;

   localparam int unsigned ADDR_WIDTH     = 16;
   localparam int unsigned DATA_WIDTH     = 8;
   localparam int unsigned MEM_ADDR_WIDTH = 21;
   localparam int unsigned ROM_BANK_WIDTH = 7;
   localparam int unsigned RAM_BANK_WIDTH = 2;

   // Low nibble that turns external RAM on.
   localparam logic [3:0] RAM_ENABLE_CODE = 4'hA;

   // Bus command.
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // 8 KiB regions, address bits 15..13.
   localparam logic [2:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [2:0] REGION_ROM_LOW    = 3'd1;
   localparam logic [2:0] REGION_BANK_HIGH  = 3'd2;
   localparam logic [2:0] REGION_MODE       = 3'd3;
   localparam logic [2:0] REGION_EXT_RAM    = 3'd5;

   typedef enum logic [1:0] {
      TARGET_NONE      = 2'd0,
      TARGET_ROM_READ  = 2'd1,
      TARGET_RAM_READ  = 2'd2,
      TARGET_RAM_WRITE = 2'd3
   } target_type;

   typedef struct packed {
      logic [ROM_BANK_WIDTH-1:0] rom_bank;
      logic [RAM_BANK_WIDTH-1:0] ram_bank;
      logic                      ram_mode;
      logic                      ram_enabled;
   } bank_state_type;

   typedef struct packed {
      logic                  command;
      logic [ADDR_WIDTH-1:0] address;
      logic [DATA_WIDTH-1:0] write_data;
   } access_type;

   typedef struct packed {
      target_type                target;
      logic [MEM_ADDR_WIDTH-1:0] memory_address;
      logic [DATA_WIDTH-1:0]     memory_data;
   } result_type;

endpackage

>>> rtl/rrbc_bank_regs.sv
// Banking control registers, updated by writes to the control ranges.
module rrbc_bank_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  logic                    has_ram,
   input  rrbc_pkg::access_type    access,
   output rrbc_pkg::bank_state_type state
);

   rrbc_pkg::bank_state_type state_ff;
   rrbc_pkg::bank_state_type state_in;
   logic [4:0]               low_bits;
   logic [2:0]               region;

   assign region   = access.address[15:13];
   assign low_bits = (access.write_data[4:0] == 5'd0) ? 5'd1 : access.write_data[4:0];

   always_comb begin
      state_in = state_ff;
      if (update && access.command == rrbc_pkg::CMD_WRITE) begin
         case (region)
            rrbc_pkg::REGION_RAM_ENABLE: begin
               if (has_ram) begin
                  state_in.ram_enabled = (access.write_data[3:0] == rrbc_pkg::RAM_ENABLE_CODE);
               end
            end
            rrbc_pkg::REGION_ROM_LOW: begin
               state_in.rom_bank[4:0] = low_bits;
            end
            rrbc_pkg::REGION_BANK_HIGH: begin
               if (state_ff.ram_mode) begin
                  state_in.ram_bank = access.write_data[1:0];
               end else begin
                  state_in.rom_bank[6:5] = access.write_data[1:0];
               end
            end
            rrbc_pkg::REGION_MODE: begin
               state_in.ram_mode = access.write_data[0];
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.rom_bank    <= 7'd1;
         state_ff.ram_bank    <= 2'd0;
         state_ff.ram_mode    <= 1'b0;
         state_ff.ram_enabled <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

>>> rtl/rrbc_addr_map.sv
// Address translation: bus access plus bank state to target and physical address.
module rrbc_addr_map (
   input  rrbc_pkg::access_type     access,
   input  rrbc_pkg::bank_state_type state,
   output rrbc_pkg::result_type     result
);

   logic [2:0]                          region;
   logic [rrbc_pkg::MEM_ADDR_WIDTH-1:0] ram_location;
   logic [rrbc_pkg::MEM_ADDR_WIDTH-1:0] rom_banked;
   logic [rrbc_pkg::MEM_ADDR_WIDTH-1:0] rom_fixed;

   assign region       = access.address[15:13];
   assign ram_location = {6'd0, state.ram_bank, access.address[12:0]};
   assign rom_banked   = {state.rom_bank, access.address[13:0]};
   assign rom_fixed    = {5'd0, access.address};

   always_comb begin
      result.target         = rrbc_pkg::TARGET_NONE;
      result.memory_address = '0;
      result.memory_data    = '0;
      if (access.command == rrbc_pkg::CMD_WRITE) begin
         if (region == rrbc_pkg::REGION_EXT_RAM) begin
            // RAM writes go through regardless of the enable
            result.target         = rrbc_pkg::TARGET_RAM_WRITE;
            result.memory_address = ram_location;
            result.memory_data    = access.write_data;
         end
      end else begin
         case (region)
            rrbc_pkg::REGION_RAM_ENABLE, rrbc_pkg::REGION_ROM_LOW: begin
               result.target         = rrbc_pkg::TARGET_ROM_READ;
               result.memory_address = rom_fixed;
            end
            rrbc_pkg::REGION_BANK_HIGH, rrbc_pkg::REGION_MODE: begin
               result.target         = rrbc_pkg::TARGET_ROM_READ;
               result.memory_address = rom_banked;
            end
            rrbc_pkg::REGION_EXT_RAM: begin
               if (state.ram_enabled) begin
                  result.target         = rrbc_pkg::TARGET_RAM_READ;
                  result.memory_address = ram_location;
               end
            end
            default: begin
               result.target = rrbc_pkg::TARGET_NONE;
            end
         endcase
      end
   end

endmodule

>>> rtl/rom_ram_bank_controller.sv
// Top level of the ROM/RAM bank controller: input stage, bank registers, mapping, result stage.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   req     | in        | req_valid/req_stall | command, address, write_data
//   rsp     | out       | rsp_valid/rsp_stall | target, memory_address, memory_data
//   csr     | in        | csr_write_enable    | has_ram (1 bit), write-only
//
// One beat per cycle sustained while rsp is not stalled; a beat goes from the input register
// through the mapping logic into the result register, which drives rsp_valid.
// Bank registers update as a beat moves to the result stage, so each beat sees the
// state left by the beat before it.
// Synchronous reset: rom_bank 1, ram_bank 0, ROM mode, RAM off, has_ram 0, stages empty.
// A stalled rsp holds the result register; req_stall rises only when both stages are full.
module rom_ram_bank_controller (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [rrbc_pkg::ADDR_WIDTH-1:0]     req_address,
   input  logic [rrbc_pkg::DATA_WIDTH-1:0]     req_write_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_target,
   output logic [rrbc_pkg::MEM_ADDR_WIDTH-1:0] rsp_memory_address,
   output logic [rrbc_pkg::DATA_WIDTH-1:0]     rsp_memory_data,

   input  logic                                csr_write_enable,
   input  logic                                csr_write_data
);

   // config
   logic has_ram_ff;

   // input stage
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   rrbc_pkg::access_type s1_access_ff;

   // result stage
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rrbc_pkg::result_type rsp_result_ff;

   rrbc_pkg::bank_state_type bank_state;
   rrbc_pkg::result_type     map_result;
   logic                     advance;
   logic                     s1_move;
   logic                     req_take;

   // result register can load when empty or being drained this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         has_ram_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            has_ram_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_access_ff.command    <= req_command;
         s1_access_ff.address    <= req_address;
         s1_access_ff.write_data <= req_write_data;
      end
      if (s1_move) begin
         rsp_result_ff <= map_result;
      end
   end

   rrbc_bank_regs u_bank_regs (
      .clock   (clock),
      .reset   (reset),
      .update  (s1_move),
      .has_ram (has_ram_ff),
      .access  (s1_access_ff),
      .state   (bank_state)
   );

   rrbc_addr_map u_addr_map (
      .access (s1_access_ff),
      .state  (bank_state),
      .result (map_result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target         = rsp_result_ff.target;
   assign rsp_memory_address = rsp_result_ff.memory_address;
   assign rsp_memory_data    = rsp_result_ff.memory_data;

   // Low ROM bank bits can never be zero.
   a_rom_bank_nonzero: assert property (@(posedge clock) disable iff (reset)
      bank_state.rom_bank[4:0] != 5'd0)
      else $error("rom bank low bits are zero");

   // Requests are held off only while the input stage holds a beat.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req stalled with empty input stage");

   // No target means no address.
   a_none_no_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target == rrbc_pkg::TARGET_NONE |-> rsp_memory_address == '0)
      else $error("address on a no-target result");

   // Data byte only rides on RAM writes.
   a_data_only_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target != rrbc_pkg::TARGET_RAM_WRITE |-> rsp_memory_data == '0)
      else $error("data byte on a non-write result");

endmodule
